// ----- sv/mfat_pkg.sv -----
package mfat_pkg;

  localparam int MAX_FRAG   = 128;
  localparam int FRAG_W     = $clog2(MAX_FRAG);
  localparam int CNT_W      = $clog2(MAX_FRAG + 1);
  localparam int GRP_W      = 8;
  localparam int GRP_IDX_W  = $clog2(GRP_W);
  localparam int N_GRP      = MAX_FRAG / GRP_W;
  localparam int GRP_SEL_W  = FRAG_W - GRP_IDX_W;

  localparam int BYTE_CNT_W = 14;
  localparam int ID_W       = 32;
  localparam int RETRY_W    = 8;
  localparam int CMD_W      = 3;
  localparam int DATA_W     = 8;
  localparam int IDX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_CNT_W-1:0] FRAG_BYTES_RST = BYTE_CNT_W'(1120);

  localparam logic [CMD_W-1:0] CMD_DATA  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_SENT  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_ACK   = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_RETRY = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_CLEAR = CMD_W'(4);

  localparam logic [CFG_IDX_W-1:0] CFG_MSG_ID     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAG_BYTES = CFG_IDX_W'(1);

  typedef struct packed {
    logic accept;
    logic scan;
    logic load;
  } dp_ctl_t;

  typedef struct packed {
    logic                 found;
    logic [GRP_IDX_W-1:0] idx;
  } grp_hit_t;

  function automatic grp_hit_t first_zero_grp(input logic [GRP_W-1:0] v);
    grp_hit_t h;
    h = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        h.found = 1'b1;
        h.idx   = GRP_IDX_W'(i);
      end
    end
    return h;
  endfunction

endpackage

// ----- sv/mfat_chan_if.sv -----
interface mfat_in_if;
  logic                          valid;
  logic                          ready;
  logic [mfat_pkg::CMD_W-1:0]    cmd;
  logic [mfat_pkg::DATA_W-1:0]   data_byte;
  logic                          last_byte;
  logic [mfat_pkg::IDX_W-1:0]    frag_index;

  modport source (output valid, cmd, data_byte, last_byte, frag_index, input ready);
  modport sink (input valid, cmd, data_byte, last_byte, frag_index, output ready);
endinterface

interface mfat_out_if;
  logic                          valid;
  logic                          ready;
  logic [mfat_pkg::ID_W-1:0]     message_ident;
  logic [mfat_pkg::DATA_W-1:0]   out_byte;
  logic [mfat_pkg::FRAG_W-1:0]   fragment_number;
  logic                          fragment_end;
  logic                          message_end;
  logic                          oversize;
  logic [mfat_pkg::FRAG_W-1:0]   first_unsent;
  logic [mfat_pkg::FRAG_W-1:0]   first_unacked;
  logic                          all_sent;
  logic                          all_acked;
  logic [mfat_pkg::RETRY_W-1:0]  retry_total;

  modport source (output valid, message_ident, out_byte, fragment_number, fragment_end,
                  message_end, oversize, first_unsent, first_unacked, all_sent,
                  all_acked, retry_total, input ready);
  modport sink (input valid, message_ident, out_byte, fragment_number, fragment_end,
                message_end, oversize, first_unsent, first_unacked, all_sent,
                all_acked, retry_total, output ready);
endinterface

interface mfat_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mfat_pkg::CFG_IDX_W-1:0]    addr;
  logic [mfat_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

// ----- sv/mfat_ctrl.sv -----
module mfat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mfat_pkg::dp_ctl_t ctl
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_LOAD} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign ctl.accept = in_valid && (state_r == ST_IDLE);
  assign ctl.scan   = (state_r == ST_SCAN);
  assign ctl.load   = (state_r == ST_LOAD) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          if (slot_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (ctl.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/mfat_dp.sv -----
module mfat_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mfat_pkg::dp_ctl_t                 ctl,
  input  logic [mfat_pkg::CMD_W-1:0]        cmd,
  input  logic [mfat_pkg::DATA_W-1:0]       data_byte,
  input  logic                              last_byte,
  input  logic [mfat_pkg::IDX_W-1:0]        frag_index,
  input  logic                              cfg_we,
  input  logic [mfat_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mfat_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [mfat_pkg::ID_W-1:0]         message_ident,
  output logic [mfat_pkg::DATA_W-1:0]       out_byte,
  output logic [mfat_pkg::FRAG_W-1:0]       fragment_number,
  output logic                              fragment_end,
  output logic                              message_end,
  output logic                              oversize,
  output logic [mfat_pkg::FRAG_W-1:0]       first_unsent,
  output logic [mfat_pkg::FRAG_W-1:0]       first_unacked,
  output logic                              all_sent,
  output logic                              all_acked,
  output logic [mfat_pkg::RETRY_W-1:0]      retry_total
);

  // config registers
  logic [mfat_pkg::ID_W-1:0]       msg_id_r;
  logic [mfat_pkg::BYTE_CNT_W-1:0] frag_bytes_r;

  // message tracking state
  logic [mfat_pkg::CNT_W-1:0]      frag_cnt_r, frag_cnt_nxt;
  logic [mfat_pkg::BYTE_CNT_W-1:0] bif_r, bif_nxt;
  logic [mfat_pkg::MAX_FRAG-1:0]   sent_r, sent_nxt;
  logic [mfat_pkg::MAX_FRAG-1:0]   acked_r, acked_nxt;
  logic [mfat_pkg::RETRY_W-1:0]    retry_r, retry_nxt;
  logic                            closed_r, closed_nxt;
  logic                            ovf_r, ovf_nxt;

  // per-item results
  logic [mfat_pkg::DATA_W-1:0]     ob_r, ob_nxt;
  logic [mfat_pkg::FRAG_W-1:0]     fnum_r, fnum_nxt;
  logic                            fend_r, fend_nxt;
  logic                            mend_r, mend_nxt;
  logic                            over_r, over_nxt;

  // first-clear search, group stage
  mfat_pkg::grp_hit_t              s_hit_r [mfat_pkg::N_GRP];
  mfat_pkg::grp_hit_t              a_hit_r [mfat_pkg::N_GRP];

  // output register
  logic [mfat_pkg::ID_W-1:0]       o_id_r;
  logic [mfat_pkg::DATA_W-1:0]     o_byte_r;
  logic [mfat_pkg::FRAG_W-1:0]     o_fnum_r;
  logic                            o_fend_r;
  logic                            o_mend_r;
  logic                            o_over_r;
  logic [mfat_pkg::FRAG_W-1:0]     o_unsent_r;
  logic [mfat_pkg::FRAG_W-1:0]     o_unacked_r;
  logic                            o_all_sent_r;
  logic                            o_all_acked_r;
  logic [mfat_pkg::RETRY_W-1:0]    o_retry_r;

  logic [mfat_pkg::BYTE_CNT_W-1:0] limit;
  logic [mfat_pkg::BYTE_CNT_W-1:0] bif_inc;
  logic [mfat_pkg::CNT_W-1:0]      cnt_open;
  logic                            opening;
  logic                            idx_ok;
  logic [mfat_pkg::FRAG_W-1:0]     idx;
  logic [mfat_pkg::MAX_FRAG-1:0]   live;
  logic [mfat_pkg::MAX_FRAG-1:0]   s_masked, a_masked;
  logic                            s_any, a_any;
  logic [mfat_pkg::FRAG_W-1:0]     s_first, a_first;

  assign limit    = (frag_bytes_r == '0) ? mfat_pkg::BYTE_CNT_W'(1) : frag_bytes_r;
  assign bif_inc  = bif_r + mfat_pkg::BYTE_CNT_W'(1);
  assign opening  = (bif_r == '0);
  assign cnt_open = opening ? frag_cnt_r + mfat_pkg::CNT_W'(1) : frag_cnt_r;
  assign idx_ok   = (frag_index < frag_cnt_r);
  assign idx      = frag_index[mfat_pkg::FRAG_W-1:0];

  always_comb begin
    frag_cnt_nxt = frag_cnt_r;
    bif_nxt      = bif_r;
    sent_nxt     = sent_r;
    acked_nxt    = acked_r;
    retry_nxt    = retry_r;
    closed_nxt   = closed_r;
    ovf_nxt      = ovf_r;
    ob_nxt       = '0;
    fnum_nxt     = '0;
    fend_nxt     = 1'b0;
    mend_nxt     = 1'b0;
    over_nxt     = 1'b0;
    unique case (cmd)
      mfat_pkg::CMD_DATA: begin
        if (!closed_r) begin
          if (ovf_r || (opening && frag_cnt_r >= mfat_pkg::CNT_W'(mfat_pkg::MAX_FRAG))) begin
            ovf_nxt  = 1'b1;
            over_nxt = 1'b1;
          end else begin
            frag_cnt_nxt = cnt_open;
            ob_nxt       = data_byte;
            fnum_nxt     = mfat_pkg::FRAG_W'(cnt_open - mfat_pkg::CNT_W'(1));
            fend_nxt     = (bif_inc >= limit) || last_byte;
            mend_nxt     = last_byte;
            bif_nxt      = ((bif_inc >= limit) || last_byte) ? '0 : bif_inc;
          end
          if (last_byte) closed_nxt = 1'b1;
        end
      end
      mfat_pkg::CMD_SENT: begin
        if (idx_ok) sent_nxt[idx] = 1'b1;
      end
      mfat_pkg::CMD_ACK: begin
        if (idx_ok) acked_nxt[idx] = 1'b1;
      end
      mfat_pkg::CMD_RETRY: begin
        retry_nxt = retry_r + mfat_pkg::RETRY_W'(1);
      end
      mfat_pkg::CMD_CLEAR: begin
        frag_cnt_nxt = '0;
        bif_nxt      = '0;
        sent_nxt     = '0;
        acked_nxt    = '0;
        retry_nxt    = '0;
        closed_nxt   = 1'b0;
        ovf_nxt      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_id_r     <= '0;
      frag_bytes_r <= mfat_pkg::FRAG_BYTES_RST;
      frag_cnt_r   <= '0;
      bif_r        <= '0;
      sent_r       <= '0;
      acked_r      <= '0;
      retry_r      <= '0;
      closed_r     <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          mfat_pkg::CFG_MSG_ID:     msg_id_r <= cfg_wdata[mfat_pkg::ID_W-1:0];
          mfat_pkg::CFG_FRAG_BYTES: frag_bytes_r <= cfg_wdata[mfat_pkg::BYTE_CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctl.accept) begin
        frag_cnt_r <= frag_cnt_nxt;
        bif_r      <= bif_nxt;
        sent_r     <= sent_nxt;
        acked_r    <= acked_nxt;
        retry_r    <= retry_nxt;
        closed_r   <= closed_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      ob_r   <= ob_nxt;
      fnum_r <= fnum_nxt;
      fend_r <= fend_nxt;
      mend_r <= mend_nxt;
      over_r <= over_nxt;
    end
  end

  // fragments past the count read as marked
  always_comb begin
    for (int i = 0; i < mfat_pkg::MAX_FRAG; i++) begin
      live[i] = (mfat_pkg::CNT_W'(i) < frag_cnt_r);
    end
  end

  assign s_masked = sent_r | ~live;
  assign a_masked = acked_r | ~live;

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      for (int g = 0; g < mfat_pkg::N_GRP; g++) begin
        s_hit_r[g] <= mfat_pkg::first_zero_grp(s_masked[g*mfat_pkg::GRP_W +: mfat_pkg::GRP_W]);
        a_hit_r[g] <= mfat_pkg::first_zero_grp(a_masked[g*mfat_pkg::GRP_W +: mfat_pkg::GRP_W]);
      end
    end
  end

  always_comb begin
    s_any   = 1'b0;
    a_any   = 1'b0;
    s_first = '0;
    a_first = '0;
    for (int g = mfat_pkg::N_GRP - 1; g >= 0; g--) begin
      if (s_hit_r[g].found) begin
        s_any   = 1'b1;
        s_first = {mfat_pkg::GRP_SEL_W'(g), s_hit_r[g].idx};
      end
      if (a_hit_r[g].found) begin
        a_any   = 1'b1;
        a_first = {mfat_pkg::GRP_SEL_W'(g), a_hit_r[g].idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      o_id_r        <= msg_id_r;
      o_byte_r      <= ob_r;
      o_fnum_r      <= fnum_r;
      o_fend_r      <= fend_r;
      o_mend_r      <= mend_r;
      o_over_r      <= over_r;
      o_unsent_r    <= s_first;
      o_unacked_r   <= a_first;
      o_all_sent_r  <= !s_any;
      o_all_acked_r <= !a_any;
      o_retry_r     <= retry_r;
    end
  end

  assign message_ident   = o_id_r;
  assign out_byte        = o_byte_r;
  assign fragment_number = o_fnum_r;
  assign fragment_end    = o_fend_r;
  assign message_end     = o_mend_r;
  assign oversize        = o_over_r;
  assign first_unsent    = o_unsent_r;
  assign first_unacked   = o_unacked_r;
  assign all_sent        = o_all_sent_r;
  assign all_acked       = o_all_acked_r;
  assign retry_total     = o_retry_r;

endmodule

// ----- sv/message_fragmenter_ack_tracker.sv -----
// Message fragmenter with per-fragment sent/acked tracking. Each command on in_ch gives exactly
// one status result on out_ch. An item passes through the state update, then a
// two-level first-clear search over the 128 sent and acked mark bits (eight-bit groups, then
// across groups): the accepting edge updates the state, the scan state registers the group hits,
// and the load state puts the result in the output register once that is free. in_ch is ready
// only when no item is in that search, so a new item is taken only after the last one is loaded;
// the result sits in an output register, so the next item is accepted while it waits, and the
// following result is held back only until the previous one is taken. The configuration port is
// always ready; write it only while the block is idle. Reset gives message id 0 and 1120-byte
// fragments, and the clear command restarts the message state without touching configuration.
module message_fragmenter_ack_tracker (
  input  logic        clk,
  input  logic        rst_n,
  mfat_in_if.sink     in_ch,
  mfat_out_if.source  out_ch,
  mfat_cfg_if.sink    cfg_ch
);

  mfat_pkg::dp_ctl_t ctl;

  assign cfg_ch.ready = 1'b1;

  mfat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  mfat_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .cmd             (in_ch.cmd),
    .data_byte       (in_ch.data_byte),
    .last_byte       (in_ch.last_byte),
    .frag_index      (in_ch.frag_index),
    .cfg_we          (cfg_ch.valid),
    .cfg_addr        (cfg_ch.addr),
    .cfg_wdata       (cfg_ch.wdata),
    .message_ident   (out_ch.message_ident),
    .out_byte        (out_ch.out_byte),
    .fragment_number (out_ch.fragment_number),
    .fragment_end    (out_ch.fragment_end),
    .message_end     (out_ch.message_end),
    .oversize        (out_ch.oversize),
    .first_unsent    (out_ch.first_unsent),
    .first_unacked   (out_ch.first_unacked),
    .all_sent        (out_ch.all_sent),
    .all_acked       (out_ch.all_acked),
    .retry_total     (out_ch.retry_total)
  );

endmodule

// ----- sv/mfat_chk.sv -----
module mfat_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic [mfat_pkg::DATA_W-1:0]     out_byte,
  input logic                            fragment_end,
  input logic                            message_end,
  input logic                            oversize,
  input logic [mfat_pkg::FRAG_W-1:0]     first_unsent,
  input logic [mfat_pkg::FRAG_W-1:0]     first_unacked,
  input logic                            all_sent,
  input logic                            all_acked
);

  // one item in the search at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_sent_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && all_sent |-> first_unsent == '0)
    else $error("first_unsent nonzero with all_sent");

  a_acked_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && all_acked |-> first_unacked == '0)
    else $error("first_unacked nonzero with all_acked");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && oversize |-> out_byte == '0 && !fragment_end && !message_end)
    else $error("dropped byte reported with data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind message_fragmenter_ack_tracker mfat_chk u_mfat_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_byte      (out_ch.out_byte),
  .fragment_end  (out_ch.fragment_end),
  .message_end   (out_ch.message_end),
  .oversize      (out_ch.oversize),
  .first_unsent  (out_ch.first_unsent),
  .first_unacked (out_ch.first_unacked),
  .all_sent      (out_ch.all_sent),
  .all_acked     (out_ch.all_acked)
);

// ----- test/message_fragmenter_ack_tracker_tb.sv -----
`timescale 1ns / 100ps

module message_fragmenter_ack_tracker_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 2000;
  localparam logic [mfat_pkg::CMD_W-1:0] CMD_SPARE_FIRST = mfat_pkg::CMD_W'(5);
  localparam logic [mfat_pkg::CMD_W-1:0] CMD_SPARE_LAST  = mfat_pkg::CMD_W'(7);

  typedef struct packed {
    logic [mfat_pkg::CMD_W-1:0]  cmd;
    logic [mfat_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;
    logic [mfat_pkg::IDX_W-1:0]  frag_index;
  } frag_cmd_t;

  typedef struct packed {
    logic [mfat_pkg::ID_W-1:0]    message_ident;
    logic [mfat_pkg::DATA_W-1:0]  out_byte;
    logic [mfat_pkg::FRAG_W-1:0]  fragment_number;
    logic                         fragment_end;
    logic                         message_end;
    logic                         oversize;
    logic [mfat_pkg::FRAG_W-1:0]  first_unsent;
    logic [mfat_pkg::FRAG_W-1:0]  first_unacked;
    logic                         all_sent;
    logic                         all_acked;
    logic [mfat_pkg::RETRY_W-1:0] retry_total;
  } frag_status_t;

  typedef struct packed {
    logic [mfat_pkg::CFG_IDX_W-1:0]  addr;
    logic [mfat_pkg::CFG_DATA_W-1:0] wdata;
  } reg_write_t;

  logic clk;
  logic rst_n;

  mfat_in_if  in_ch();
  mfat_out_if out_ch();
  mfat_cfg_if cfg_ch();

  message_fragmenter_ack_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frag_cmd_t    cmd_q[$];
  frag_status_t status_q[$];
  reg_write_t   reg_q[$];

  // tracker shadow
  logic [mfat_pkg::ID_W-1:0]       msg_id_reg = '0;
  logic [mfat_pkg::BYTE_CNT_W-1:0] frag_limit_reg = mfat_pkg::FRAG_BYTES_RST;
  int                              frag_count = 0;
  int                              frag_fill = 0;
  logic [mfat_pkg::MAX_FRAG-1:0]   sent_bits = '0;
  logic [mfat_pkg::MAX_FRAG-1:0]   acked_bits = '0;
  logic [mfat_pkg::RETRY_W-1:0]    retry_cnt = '0;
  logic                            msg_closed = 1'b0;
  logic                            overflow = 1'b0;

  int        in_mode = 0;
  int        out_mode = 0;
  int        in_gap;
  int        out_wait;
  int        n_fail = 0;
  int        n_random = 0;
  bit        random_part = 0;
  int        cycles = 0;
  frag_cmd_t in_cur;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pause_len(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 19);
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
  endfunction

  function automatic frag_status_t next_status(input frag_cmd_t c);
    frag_status_t s;
    int limit;
    s = '0;
    case (c.cmd)
      mfat_pkg::CMD_DATA: begin
        if (!msg_closed) begin
          limit = (frag_limit_reg == 0) ? 1 : int'(frag_limit_reg);
          if (overflow || (frag_fill == 0 && frag_count >= mfat_pkg::MAX_FRAG)) begin
            overflow = 1'b1;
            s.oversize = 1'b1;
          end else begin
            if (frag_fill == 0) begin
              sent_bits[frag_count] = 1'b0;
              acked_bits[frag_count] = 1'b0;
              frag_count++;
            end
            frag_fill++;
            s.out_byte = c.data_byte;
            s.fragment_number = mfat_pkg::FRAG_W'(frag_count - 1);
            s.fragment_end = (frag_fill >= limit) || c.last_byte;
            s.message_end = c.last_byte;
            if (s.fragment_end) frag_fill = 0;
          end
          if (c.last_byte) msg_closed = 1'b1;
        end
      end
      mfat_pkg::CMD_SENT: begin
        if (int'(c.frag_index) < frag_count) sent_bits[c.frag_index] = 1'b1;
      end
      mfat_pkg::CMD_ACK: begin
        if (int'(c.frag_index) < frag_count) acked_bits[c.frag_index] = 1'b1;
      end
      mfat_pkg::CMD_RETRY: retry_cnt = retry_cnt + 1'b1;
      mfat_pkg::CMD_CLEAR: begin
        frag_count = 0;
        frag_fill = 0;
        sent_bits = '0;
        acked_bits = '0;
        retry_cnt = '0;
        msg_closed = 1'b0;
        overflow = 1'b0;
      end
      default: ;
    endcase
    s.all_sent = 1'b1;
    s.all_acked = 1'b1;
    for (int i = frag_count - 1; i >= 0; i--) begin
      if (!sent_bits[i]) begin
        s.all_sent = 1'b0;
        s.first_unsent = mfat_pkg::FRAG_W'(i);
      end
      if (!acked_bits[i]) begin
        s.all_acked = 1'b0;
        s.first_unacked = mfat_pkg::FRAG_W'(i);
      end
    end
    s.message_ident = msg_id_reg;
    s.retry_total = retry_cnt;
    return s;
  endfunction

  function automatic string show(input frag_status_t s);
    return $sformatf({"id=%h byte=%h frag=%0d fend=%b mend=%b over=%b unsent=%0d ",
                      "unacked=%0d all_sent=%b all_acked=%b retry=%0d"},
                     s.message_ident, s.out_byte, s.fragment_number, s.fragment_end,
                     s.message_end, s.oversize, s.first_unsent, s.first_unacked,
                     s.all_sent, s.all_acked, s.retry_total);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) status_q.insert(status_q.size(), next_status(in_cur));
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (cmd_q.size() != 0) begin
          in_cur = cmd_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= in_cur.cmd;
          in_ch.data_byte <= in_cur.data_byte;
          in_ch.last_byte <= in_cur.last_byte;
          in_ch.frag_index <= in_cur.frag_index;
          in_gap <= pause_len(in_mode);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk) begin : reg_driver
    reg_write_t w;
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          mfat_pkg::CFG_MSG_ID:     msg_id_reg = cfg_ch.wdata;
          mfat_pkg::CFG_FRAG_BYTES: frag_limit_reg = cfg_ch.wdata[mfat_pkg::BYTE_CNT_W-1:0];
          default: ;
        endcase
      end
      if (!(cfg_ch.valid && !cfg_ch.ready)) begin
        if (reg_q.size() != 0) begin
          w = reg_q.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.addr <= w.addr;
          cfg_ch.wdata <= w.wdata;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    int w;
    frag_status_t got;
    frag_status_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      w = out_wait;
      if (out_ch.valid && out_ch.ready) begin
        got.message_ident = out_ch.message_ident;
        got.out_byte = out_ch.out_byte;
        got.fragment_number = out_ch.fragment_number;
        got.fragment_end = out_ch.fragment_end;
        got.message_end = out_ch.message_end;
        got.oversize = out_ch.oversize;
        got.first_unsent = out_ch.first_unsent;
        got.first_unacked = out_ch.first_unacked;
        got.all_sent = out_ch.all_sent;
        got.all_acked = out_ch.all_acked;
        got.retry_total = out_ch.retry_total;
        if (status_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("mismatch at cycle %0d", cycles);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
        w = pause_len(out_mode);
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        out_wait <= w - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("message_fragmenter_ack_tracker_tb: FAIL");
      $finish;
    end
  end

  task automatic push_cmd(input logic [mfat_pkg::CMD_W-1:0] cmd,
                          input logic [mfat_pkg::DATA_W-1:0] data,
                          input logic last, input logic [mfat_pkg::IDX_W-1:0] idx);
    frag_cmd_t c;
    c.cmd = cmd;
    c.data_byte = data;
    c.last_byte = last;
    c.frag_index = idx;
    cmd_q.insert(cmd_q.size(), c);
    if (random_part) n_random++;
  endtask

  task automatic push_side(input logic [mfat_pkg::CMD_W-1:0] cmd, input int idx);
    push_cmd(cmd, mfat_pkg::DATA_W'($urandom), 1'($urandom), mfat_pkg::IDX_W'(idx));
  endtask

  task automatic write_reg(input logic [mfat_pkg::CFG_IDX_W-1:0] addr,
                           input logic [mfat_pkg::CFG_DATA_W-1:0] v);
    reg_write_t w;
    w.addr = addr;
    w.wdata = v;
    reg_q.insert(reg_q.size(), w);
  endtask

  task automatic settle();
    while (cmd_q.size() != 0 || in_ch.valid || status_q.size() != 0 ||
           reg_q.size() != 0 || cfg_ch.valid)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // one message: optional clear, bytes with marks mixed in, then marking
  task automatic send_message();
    int unit;
    int len;
    int est;
    bit finish;
    unit = (frag_limit_reg == 0) ? 1 : int'(frag_limit_reg);
    est = 0;
    if ($urandom_range(0, 3) != 0) push_side(mfat_pkg::CMD_CLEAR, $urandom_range(0, 255));
    if (unit <= 3 && $urandom_range(0, 5) == 0)
      len = mfat_pkg::MAX_FRAG * unit + $urandom_range(0, 6) - 3;
    else
      len = $urandom_range(1, 24);
    finish = ($urandom_range(0, 7) != 0);
    for (int k = 0; k < len; k++) begin
      push_cmd(mfat_pkg::CMD_DATA, mfat_pkg::DATA_W'($urandom), finish && (k == len - 1),
               mfat_pkg::IDX_W'($urandom));
      est = (k + unit) / unit;
      if (est > mfat_pkg::MAX_FRAG) est = mfat_pkg::MAX_FRAG;
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: push_side(mfat_pkg::CMD_SENT, $urandom_range(0, est));
          4, 5, 6:    push_side(mfat_pkg::CMD_ACK, $urandom_range(0, est));
          7:          push_side(mfat_pkg::CMD_RETRY, $urandom_range(0, 255));
          8: push_side(mfat_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                       $urandom_range(0, 255));
          default: push_side($urandom_range(0, 1) ? mfat_pkg::CMD_SENT : mfat_pkg::CMD_ACK,
                             $urandom_range(0, 255));
        endcase
      end
    end
    if (finish) begin
      if ($urandom_range(0, 1) == 0) begin
        for (int i = 0; i < est; i++) push_side(mfat_pkg::CMD_SENT, i);
        for (int i = 0; i < est; i++) push_side(mfat_pkg::CMD_ACK, i);
      end else begin
        repeat ($urandom_range(0, 6))
          push_side($urandom_range(0, 1) ? mfat_pkg::CMD_SENT : mfat_pkg::CMD_ACK,
                    $urandom_range(0, est));
      end
      if ($urandom_range(0, 7) == 0)
        push_cmd(mfat_pkg::CMD_DATA, mfat_pkg::DATA_W'($urandom), 1'($urandom),
                 mfat_pkg::IDX_W'($urandom));
    end
    if ($urandom_range(0, 11) == 0)
      repeat (258) push_side(mfat_pkg::CMD_RETRY, $urandom_range(0, 255));
  endtask

  initial begin
    int sz;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = mfat_pkg::CMD_DATA;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.frag_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = mfat_pkg::CFG_MSG_ID;
    cfg_ch.wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // status with no fragments, marks past count, spare commands
    push_cmd(mfat_pkg::CMD_RETRY, 8'h00, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_SENT, 8'hff, 1'b1, 8'h00);
    push_cmd(mfat_pkg::CMD_ACK, 8'h00, 1'b0, 8'hff);
    push_cmd(CMD_SPARE_FIRST, 8'h12, 1'b0, 8'h01);
    push_cmd(mfat_pkg::CMD_W'(CMD_SPARE_FIRST + 1), 8'h34, 1'b1, 8'h02);
    push_cmd(CMD_SPARE_LAST, 8'hff, 1'b1, 8'hff);
    // bytes, marking the fragment still being filled
    push_cmd(mfat_pkg::CMD_DATA, 8'h00, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_DATA, 8'hff, 1'b0, 8'hff);
    push_cmd(mfat_pkg::CMD_SENT, 8'h00, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_ACK, 8'h00, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_SENT, 8'h00, 1'b0, 8'h01);
    push_cmd(mfat_pkg::CMD_RETRY, 8'h00, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_DATA, 8'ha5, 1'b1, 8'h80);
    // byte after message end is ignored
    push_cmd(mfat_pkg::CMD_DATA, 8'h5a, 1'b1, 8'h7f);
    push_cmd(mfat_pkg::CMD_CLEAR, 8'hff, 1'b1, 8'hff);
    settle();

    // zero size behaves as one byte per fragment
    write_reg(mfat_pkg::CFG_MSG_ID, 32'hffff_ffff);
    write_reg(mfat_pkg::CFG_FRAG_BYTES, 32'd0);
    settle();
    push_cmd(mfat_pkg::CMD_DATA, 8'h01, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_DATA, 8'h02, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_DATA, 8'h03, 1'b1, 8'h00);
    push_cmd(mfat_pkg::CMD_CLEAR, 8'h00, 1'b0, 8'h00);
    settle();
    write_reg(mfat_pkg::CFG_FRAG_BYTES, 32'd3);
    settle();
    push_cmd(mfat_pkg::CMD_DATA, 8'h10, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_DATA, 8'h11, 1'b0, 8'h00);
    settle();
    // size lowered under an open fragment
    write_reg(mfat_pkg::CFG_FRAG_BYTES, 32'd1);
    settle();
    push_cmd(mfat_pkg::CMD_DATA, 8'h12, 1'b0, 8'h00);
    push_cmd(mfat_pkg::CMD_DATA, 8'h13, 1'b1, 8'h00);
    settle();

    random_part = 1;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 8))
        0: sz = 0;
        1: sz = 1;
        2: sz = 2;
        3: sz = 3;
        4: sz = 16383;
        5: sz = int'(mfat_pkg::FRAG_BYTES_RST);
        default: sz = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(mfat_pkg::CFG_MSG_ID, $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff);
        1: write_reg(mfat_pkg::CFG_FRAG_BYTES, sz);
        2: begin
          write_reg(mfat_pkg::CFG_MSG_ID, $urandom);
          write_reg(mfat_pkg::CFG_FRAG_BYTES, sz);
        end
        default: ;
      endcase
      in_mode = $urandom_range(0, 2);
      out_mode = $urandom_range(0, 2);
      settle();
      repeat ($urandom_range(1, 3)) send_message();
      settle();
    end

    settle();
    if (n_fail == 0 && status_q.size() == 0) begin
      $display("message_fragmenter_ack_tracker_tb: PASS");
    end else begin
      $display("message_fragmenter_ack_tracker_tb: FAIL");
    end
    $finish;
  end

endmodule
